// ===== rtl/bmc_pkg.sv =====
package bmc_pkg;

    localparam int LEVEL_W     = 8;
    localparam int DUTY_W      = 12;
    localparam int TIMER_W     = 16;
    localparam int STEP_W      = 8;
    localparam int MODE_W      = 3;
    localparam int DAY_W       = 2;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int DUTY_LEVELS = 12;
    localparam int TABLE_DEPTH = 32;
    localparam int TABLE_IDX_W = 5;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 12'd3000;

    localparam logic [DUTY_W-1:0] DUTY_TABLE [TABLE_DEPTH] = '{
        12'd0,    12'd300,  12'd480,  12'd660,  12'd840,  12'd990,
        12'd1140, 12'd1500, 12'd1860, 12'd2220, 12'd2610, 12'd3000,
        12'd3000, 12'd3000, 12'd3000, 12'd3000, 12'd3000, 12'd3000,
        12'd3000, 12'd3000, 12'd3000, 12'd3000, 12'd3000, 12'd3000,
        12'd3000, 12'd3000, 12'd3000, 12'd3000, 12'd3000, 12'd3000,
        12'd3000, 12'd3000
    };

    localparam logic [LEVEL_W-1:0] NIGHT_MIN = 8'd1;
    localparam logic [LEVEL_W-1:0] NIGHT_MAX = 8'd11;
    localparam logic [LEVEL_W-1:0] DAY_MIN   = 8'd12;
    localparam logic [LEVEL_W-1:0] DAY_MAX   = 8'd22;

    localparam logic [DAY_W-1:0] DAY_UNKNOWN = 2'd0;
    localparam logic [DAY_W-1:0] DAY_NIGHT   = 2'd1;
    localparam logic [DAY_W-1:0] DAY_DAY     = 2'd2;

    localparam logic [MODE_W-1:0] MODE_CODE_NORMAL  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_OFF     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_FAIL    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CODE_DELAY   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CODE_OTA     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CODE_OTA_DLY = 3'd5;

    localparam logic [1:0] REG_FAIL_OFF_DELAY = 2'd0;
    localparam logic [1:0] REG_OTA_EXIT_DELAY = 2'd1;
    localparam logic [1:0] REG_OTA_TIMEOUT    = 2'd2;
    localparam logic [1:0] REG_RAMP_STEP      = 2'd3;

    typedef enum logic [5:0] {
        MODE_NORMAL  = 6'b000001,
        MODE_OFF     = 6'b000010,
        MODE_FAIL    = 6'b000100,
        MODE_DELAY   = 6'b001000,
        MODE_OTA     = 6'b010000,
        MODE_OTA_DLY = 6'b100000
    } bmc_mode_t;

    typedef struct packed {
        logic [TIMER_W-1:0] fail_off_delay;
        logic [TIMER_W-1:0] ota_exit_delay;
        logic [TIMER_W-1:0] ota_timeout;
        logic [STEP_W-1:0]  ramp_step;
    } bmc_cfg_t;

    typedef struct packed {
        bmc_mode_t          cur_mode;
        bmc_mode_t          prev_mode;
        logic [DUTY_W-1:0]  target_duty;
        logic [DUTY_W-1:0]  prev_target;
        logic [DUTY_W-1:0]  ramped_duty;
        logic [TIMER_W-1:0] tick_timer;
        logic [TIMER_W-1:0] minute_timer;
        logic [DAY_W-1:0]   day_flag;
    } bmc_state_t;

    localparam bmc_state_t STATE_RESET = '{
        cur_mode:     MODE_NORMAL,
        prev_mode:    MODE_NORMAL,
        target_duty:  '0,
        prev_target:  '0,
        ramped_duty:  '0,
        tick_timer:   '0,
        minute_timer: '0,
        day_flag:     DAY_UNKNOWN
    };

    function automatic logic [DUTY_W-1:0] duty_lookup(input logic [LEVEL_W-1:0] level);
        logic [LEVEL_W-1:0] idx;
        idx = level;
        if (idx > LEVEL_W'(DUTY_LEVELS - 1))
        begin
            idx = LEVEL_W'(DUTY_LEVELS - 1);
        end
        if (idx > LEVEL_W'(TABLE_DEPTH - 1))
        begin
            idx = LEVEL_W'(TABLE_DEPTH - 1);
        end
        return DUTY_TABLE[idx[TABLE_IDX_W-1:0]];
    endfunction

    function automatic logic [MODE_W-1:0] mode_code(input bmc_mode_t m);
        logic [MODE_W-1:0] code;
        unique case (m)
            MODE_NORMAL:  code = MODE_CODE_NORMAL;
            MODE_OFF:     code = MODE_CODE_OFF;
            MODE_FAIL:    code = MODE_CODE_FAIL;
            MODE_DELAY:   code = MODE_CODE_DELAY;
            MODE_OTA:     code = MODE_CODE_OTA;
            MODE_OTA_DLY: code = MODE_CODE_OTA_DLY;
            default:      code = MODE_CODE_NORMAL;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/bmc_if.sv =====
interface bmc_tick_if
    import bmc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] light_level;
    logic               voltage_normal;
    logic               ota_request;
    logic               gear_on;

    modport source (output valid, output light_level, output voltage_normal,
                    output ota_request, output gear_on, input ready);
    modport sink   (input valid, input light_level, input voltage_normal,
                    input ota_request, input gear_on, output ready);
endinterface

interface bmc_status_if
    import bmc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] pwm_duty;
    logic [MODE_W-1:0] mode;
    logic [DAY_W-1:0]  day_night;
    logic              ota_clear;

    modport source (output valid, output pwm_duty, output mode, output day_night,
                    output ota_clear, input ready);
    modport sink   (input valid, input pwm_duty, input mode, input day_night,
                    input ota_clear, output ready);
endinterface

// ===== rtl/backlight_mode_controller_unit.sv =====
// Channel   Role  Beat contents
// tick      sink  light_level, voltage_normal, ota_request, gear_on
// status    src   pwm_duty, mode, day_night, ota_clear
// APB       cfg   fail_off_delay 0x0, ota_exit_delay 0x4, ota_timeout 0x8, ramp_step 0xC
//
// Each tick beat is worked combinationally by the mode logic between the state registers
// and the status register; the status beat appears the cycle after acceptance.
// A new tick is taken every cycle while the status register is empty or being drained,
// so a stalled status side holds one result and stops further ticks.
// Asynchronous reset returns the mode state to normal, empties the status register and
// loads the default configuration.
module backlight_mode_controller_unit
    import bmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    bmc_tick_if.sink              tick,
    bmc_status_if.source          status
);

    bmc_cfg_t          cfg_reg;
    bmc_state_t        state_reg;
    bmc_state_t        state_next;
    logic              clear_next;
    logic              accept;
    logic              valid_reg;
    logic [DUTY_W-1:0] duty_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [DAY_W-1:0]  day_reg;
    logic              clear_reg;
    logic [1:0]        reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fail_off_delay <= 16'd200;
            cfg_reg.ota_exit_delay <= 16'd300;
            cfg_reg.ota_timeout    <= 16'd18000;
            cfg_reg.ramp_step      <= 8'd30;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_index)
                REG_FAIL_OFF_DELAY: cfg_reg.fail_off_delay <= pwdata[TIMER_W-1:0];
                REG_OTA_EXIT_DELAY: cfg_reg.ota_exit_delay <= pwdata[TIMER_W-1:0];
                REG_OTA_TIMEOUT:    cfg_reg.ota_timeout    <= pwdata[TIMER_W-1:0];
                REG_RAMP_STEP:      cfg_reg.ramp_step      <= pwdata[STEP_W-1:0];
                default:            cfg_reg.ramp_step      <= cfg_reg.ramp_step;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_FAIL_OFF_DELAY: prdata = APB_DATA_W'(cfg_reg.fail_off_delay);
            REG_OTA_EXIT_DELAY: prdata = APB_DATA_W'(cfg_reg.ota_exit_delay);
            REG_OTA_TIMEOUT:    prdata = APB_DATA_W'(cfg_reg.ota_timeout);
            REG_RAMP_STEP:      prdata = APB_DATA_W'(cfg_reg.ramp_step);
            default:            prdata = '0;
        endcase
    end

    assign tick.ready = !valid_reg || status.ready;
    assign accept     = tick.valid && tick.ready;

    bmc_core u_core (
        .state          (state_reg),
        .cfg            (cfg_reg),
        .light_level    (tick.light_level),
        .voltage_normal (tick.voltage_normal),
        .ota_request    (tick.ota_request),
        .gear_on        (tick.gear_on),
        .state_next     (state_next),
        .ota_clear      (clear_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                valid_reg <= 1'b1;
            end
            else if (status.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            duty_reg  <= state_next.ramped_duty;
            mode_reg  <= mode_code(state_next.cur_mode);
            day_reg   <= state_next.day_flag;
            clear_reg <= clear_next;
        end
    end

    assign status.valid     = valid_reg;
    assign status.pwm_duty  = duty_reg;
    assign status.mode      = mode_reg;
    assign status.day_night = day_reg;
    assign status.ota_clear = clear_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !tick.voltage_normal) |=> (status.valid && status.mode == MODE_CODE_OFF))
        else $error("supply fault beat did not report off mode");

    assert property (@(posedge clk) disable iff (!rst_n)
        (status.valid && status.ota_clear) |-> (state_reg.minute_timer == '0))
        else $error("OTA clear reported while the minute timer is still running");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.target_duty <= DUTY_MAX) && (state_reg.ramped_duty <= DUTY_MAX))
        else $error("duty beyond the table maximum");

    assert property (@(posedge clk) disable iff (!rst_n)
        (status.valid && !status.ready) |-> !tick.ready)
        else $error("tick taken while a stalled status beat is held");

endmodule

// ===== rtl/bmc_core.sv =====
module bmc_core
    import bmc_pkg::*;
(
    input  bmc_state_t         state,
    input  bmc_cfg_t           cfg,
    input  logic [LEVEL_W-1:0] light_level,
    input  logic               voltage_normal,
    input  logic               ota_request,
    input  logic               gear_on,
    output bmc_state_t         state_next,
    output logic               ota_clear
);

    logic              night;
    logic              day;
    logic              light_ok;
    logic [DUTY_W:0]   ramp_up;
    logic [DUTY_W-1:0] step;

    assign night    = (light_level >= NIGHT_MIN) && (light_level <= NIGHT_MAX);
    assign day      = (light_level >= DAY_MIN) && (light_level <= DAY_MAX);
    assign light_ok = night || day;
    assign step     = DUTY_W'(cfg.ramp_step);

    always_comb
    begin
        bmc_state_t n;
        n         = state;
        ota_clear = 1'b0;
        ramp_up   = '0;

        if (night)
        begin
            n.day_flag = DAY_NIGHT;
        end
        else if (day)
        begin
            n.day_flag = DAY_DAY;
        end

        if (n.minute_timer != '0)
        begin
            n.minute_timer = n.minute_timer - TIMER_W'(1);
        end

        if (!voltage_normal)
        begin
            n.prev_mode   = n.cur_mode;
            n.prev_target = n.target_duty;
            n.cur_mode    = MODE_OFF;
        end

        unique case (n.cur_mode)
            MODE_OFF:
            begin
                if (voltage_normal)
                begin
                    n.prev_mode   = n.cur_mode;
                    n.prev_target = n.target_duty;
                    n.cur_mode    = MODE_NORMAL;
                end
                n.target_duty = duty_lookup('0);
            end
            MODE_NORMAL:
            begin
                if (ota_request)
                begin
                    n.minute_timer = cfg.ota_timeout;
                    n.prev_mode    = n.cur_mode;
                    n.prev_target  = n.target_duty;
                    n.cur_mode     = MODE_OTA;
                    n.target_duty  = duty_lookup('0);
                end
                else if (day)
                begin
                    n.target_duty = duty_lookup('0);
                end
                else if (night)
                begin
                    n.target_duty = duty_lookup(light_level);
                end
                else
                begin
                    n.prev_mode   = n.cur_mode;
                    n.prev_target = n.target_duty;
                    n.cur_mode    = MODE_FAIL;
                end
            end
            MODE_FAIL, MODE_DELAY:
            begin
                if (ota_request)
                begin
                    n.minute_timer = cfg.ota_timeout;
                    n.prev_mode    = n.cur_mode;
                    n.prev_target  = n.target_duty;
                    n.cur_mode     = MODE_OTA;
                    n.target_duty  = duty_lookup('0);
                end
                else if (light_ok)
                begin
                    n.prev_mode   = n.cur_mode;
                    n.prev_target = n.target_duty;
                    n.cur_mode    = MODE_NORMAL;
                end
                else if (n.cur_mode == MODE_FAIL)
                begin
                    if (!gear_on)
                    begin
                        n.tick_timer  = cfg.fail_off_delay;
                        n.prev_mode   = n.cur_mode;
                        n.prev_target = n.target_duty;
                        n.cur_mode    = MODE_DELAY;
                    end
                end
                else
                begin
                    if (n.tick_timer != '0)
                    begin
                        n.tick_timer = n.tick_timer - TIMER_W'(1);
                    end
                    if (n.tick_timer == '0)
                    begin
                        n.target_duty = duty_lookup('0);
                    end
                end
            end
            MODE_OTA:
            begin
                if (!ota_request)
                begin
                    n.tick_timer  = cfg.ota_exit_delay;
                    n.prev_mode   = n.cur_mode;
                    n.prev_target = n.target_duty;
                    n.cur_mode    = MODE_OTA_DLY;
                end
                else if (n.minute_timer == '0)
                begin
                    n.cur_mode    = n.prev_mode;
                    n.target_duty = n.prev_target;
                    ota_clear     = 1'b1;
                end
            end
            MODE_OTA_DLY:
            begin
                if (n.tick_timer != '0)
                begin
                    n.tick_timer = n.tick_timer - TIMER_W'(1);
                end
                if (n.tick_timer == '0)
                begin
                    n.prev_mode   = n.cur_mode;
                    n.prev_target = n.target_duty;
                    n.cur_mode    = MODE_NORMAL;
                end
            end
            default:
            begin
                n = STATE_RESET;
            end
        endcase

        if (n.target_duty > n.ramped_duty)
        begin
            ramp_up = {1'b0, n.ramped_duty} + {1'b0, step};
            if (ramp_up > {1'b0, n.target_duty})
            begin
                n.ramped_duty = n.target_duty;
            end
            else
            begin
                n.ramped_duty = ramp_up[DUTY_W-1:0];
            end
        end
        else if (n.target_duty < n.ramped_duty)
        begin
            if (n.ramped_duty >= step)
            begin
                n.ramped_duty = n.ramped_duty - step;
            end
            else
            begin
                n.ramped_duty = '0;
            end
        end

        state_next = n;
    end

endmodule
